[rtl/mtg_pkg.sv]
// Shared constants, opcodes and state type of the mesh tangent generator.
`timescale 1ns / 1ps

package mtg_pkg;

    // vertex count and field widths
    localparam int VERTEX_MAX = 4096;
    localparam int IDX_W      = 12;
    localparam int ADDR_W     = $clog2(VERTEX_MAX);
    localparam int COORD_W    = 32;
    localparam int NORM_W     = 19;
    localparam int SUM_W      = 48;
    localparam int TAN_W      = 18;

    // one vertex row: pos x,y,z, tex u,v, normal x,y,z from the low bit up
    localparam int VROW_W = 5 * COORD_W + 3 * NORM_W;
    // one tangent sum row: x,y,z from the low bit up
    localparam int SROW_W = 3 * SUM_W;

    // shared divider and multiplier widths
    localparam int DVD_W = 65;
    localparam int DVS_W = 49;
    localparam int MUL_W = 34;

    // item opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_TR_RD,
        S_TR_DELTA,
        S_TR_MUL,
        S_TR_DET,
        S_TR_DIV,
        S_TR_DIVW,
        S_TR_SRD,
        S_TR_SWR,
        S_RD_RD,
        S_RD_CAP,
        S_RD_NORM1,
        S_RD_DOT,
        S_RD_PROJ,
        S_RD_MAX,
        S_RD_NORM2,
        S_RD_LEN,
        S_RD_SQRT,
        S_RD_DIV,
        S_RD_DIVW,
        S_RD_OUT
    } t_state;

endpackage

[rtl/mtg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mtg_div.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps

module mtg_div import mtg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_div;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;

    // trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend out and quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_fit};
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_div}) : DVS_W'(w_trial);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/mesh_tangent_generator.sv]
// Top level of the per-vertex tangent generator (Q16.16 fixed point).
`timescale 1ns / 1ps

// Per-vertex tangent generator. Items enter on the slave stream, one at a time; tuser
// carries the opcode (load vertex, triangle, read tangent). Vertex data sits in one
// 4096-row RAM and tangent sums in a second; a load writes both rows. A triangle
// reads its three corners, forms the UV determinant with one shared 34x34
// multiplier, runs three quotients through a shared divider that retires one bit
// per cycle and then read-modify-writes the three sum rows; a zero determinant
// ends it before the divides. A read uses normalizing shifts of one bit a cycle, a
// 32-step bitwise square root and three more divides. Repeated corners are safe since
// each sum write lands before the next corner's read. No clearing pass runs after
// reset: a vertex load clears its own tangent sum. Only reads produce a result beat.
module mesh_tangent_generator import mtg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // vertex_index, corner_b, corner_c, pos_x, pos_y, pos_z, tex_u, tex_v,
    // norm_x, norm_y, norm_z, zero pad
    input  logic [255:0] i_s_tdata,
    // opcode
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // read_index, tan_x, tan_y, tan_z, zero pad
    output logic [71:0]  o_m_tdata,
    // zero_length
    output logic [0:0]   o_m_tuser
);

    localparam logic [SUM_W-1:0] LIM30 = SUM_W'(64'd1 << 30);
    localparam logic [SUM_W-1:0] LIM29 = SUM_W'(64'd1 << 29);
    localparam logic [DVD_W-1:0] Q_POS_LIM = DVD_W'((64'd1 << 47) - 64'd1);
    localparam logic [DVD_W-1:0] Q_NEG_LIM = DVD_W'(64'd1 << 47);
    localparam logic [63:0]      SQRT_BIT0 = 64'd1 << 62;

    // ---------------------------------------------------------------- helpers
    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < VERTEX_MAX);
    endfunction

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W:0] d);
        if (d[COORD_W] != d[COORD_W-1]) begin
            return d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        return d[COORD_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] d);
        if (d[SUM_W] != d[SUM_W-1]) begin
            return d[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return d[SUM_W-1:0];
    endfunction

    function automatic logic [DVS_W-1:0] abs49(input logic [DVS_W-1:0] x);
        return x[DVS_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [SUM_W-1:0] abs48(input logic [SUM_W-1:0] x);
        return x[SUM_W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [39:0] abs40(input logic [39:0] x);
        return x[39] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [COORD_W-1:0] row_pos(input logic [VROW_W-1:0] row,
                                                           input int j);
        return row[j*COORD_W +: COORD_W];
    endfunction

    function automatic logic signed [COORD_W-1:0] row_tex(input logic [VROW_W-1:0] row,
                                                           input int j);
        return row[(3+j)*COORD_W +: COORD_W];
    endfunction

    function automatic logic signed [NORM_W-1:0] row_norm(input logic [VROW_W-1:0] row,
                                                           input int j);
        return row[5*COORD_W + j*NORM_W +: NORM_W];
    endfunction

    // ---------------------------------------------------------------- state
    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    logic [1:0]        r_op;
    logic [IDX_W-1:0]  r_ia, r_ib, r_ic;
    logic [VROW_W-1:0] r_row_in;
    logic [VROW_W-1:0] r_vrow [3];

    logic signed [COORD_W-1:0] r_s1, r_t1, r_s2, r_t2;
    logic signed [COORD_W-1:0] r_e1 [3];
    logic signed [COORD_W-1:0] r_e2 [3];
    logic signed [SUM_W-1:0]   r_pp [8];
    logic [DVS_W-1:0]          r_det;
    logic [DVS_W-1:0]          r_num [3];
    logic signed [SUM_W-1:0]   r_sdir [3];

    logic signed [SUM_W-1:0]   r_t [3];
    logic signed [NORM_W-1:0]  r_n [3];
    logic [SUM_W-1:0]          r_m;
    logic signed [39:0]        r_o [3];
    logic [63:0]               r_acc;
    logic [63:0]               r_root;
    logic [63:0]               r_bit;
    logic [TAN_W-1:0]          r_tan [3];
    logic                      r_zlen;

    logic                      r_ov;
    logic [IDX_W-1:0]          r_od_idx;
    logic [TAN_W-1:0]          r_od_tan [3];
    logic                      r_od_z;

    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [MUL_W-1:0]   w_ma, w_mb;

    logic              w_s_fire;
    logic [1:0]        w_in_op;
    logic [IDX_W-1:0]  w_in_a, w_in_b, w_in_c;
    logic [ADDR_W-1:0] w_vaddr, w_saddr, w_swaddr, w_corner;
    logic              w_vwe, w_swe;
    logic [SROW_W-1:0] w_swdata, w_sum_new;
    logic [VROW_W-1:0] w_vrdata;
    logic [SROW_W-1:0] w_srdata;
    logic              w_div_start, w_div_done;
    logic [DVD_W-1:0]  w_dvd, w_quo;
    logic [DVS_W-1:0]  w_dvs;
    logic [DVS_W-1:0]  w_det;
    logic [SUM_W-1:0]  w_tmax;
    logic [39:0]       w_omax;
    logic [63:0]       w_sq_try;
    logic              w_out_free;
    logic [1:0]        w_j;

    // ---------------------------------------------------------------- input fields
    assign w_s_fire = i_s_tvalid && o_s_tready;
    assign w_in_op  = i_s_tuser;
    assign w_in_a   = i_s_tdata[11:0];
    assign w_in_b   = i_s_tdata[23:12];
    assign w_in_c   = i_s_tdata[35:24];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_out_free = !r_ov || i_m_tready;
    assign w_j = r_cnt[1:0];

    // corner selected by the step counter
    always_comb begin
        unique case (w_j)
            2'd0:    w_corner = ADDR_W'(r_ia);
            2'd1:    w_corner = ADDR_W'(r_ib);
            default: w_corner = ADDR_W'(r_ic);
        endcase
    end

    // ---------------------------------------------------------------- memories
    mtg_ram #(.WIDTH(VROW_W), .DEPTH(VERTEX_MAX)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (ADDR_W'(r_ia)),
        .i_wdata (r_row_in),
        .i_raddr (w_vaddr),
        .o_rdata (w_vrdata)
    );

    mtg_ram #(.WIDTH(SROW_W), .DEPTH(VERTEX_MAX)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_waddr (w_swaddr),
        .i_wdata (w_swdata),
        .i_raddr (w_saddr),
        .o_rdata (w_srdata)
    );

    mtg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ---------------------------------------------------------------- datapath helpers
    // determinant from the scaled products
    assign w_det = DVS_W'($signed(r_pp[0]) - $signed(r_pp[1]));

    // saturating add of the s-direction into the sum row just read
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum_new[j*SUM_W +: SUM_W] =
                sat48($signed(w_srdata[j*SUM_W +: SUM_W]) + $signed(r_sdir[j]));
        end
    end

    // largest magnitudes of the sum and of the projected vector
    always_comb begin
        w_tmax = '0;
        w_omax = '0;
        for (int j = 0; j < 3; j++) begin
            if (abs48(w_srdata[j*SUM_W +: SUM_W]) > w_tmax) begin
                w_tmax = abs48(w_srdata[j*SUM_W +: SUM_W]);
            end
            if (abs40(r_o[j]) > w_omax) begin
                w_omax = abs40(r_o[j]);
            end
        end
    end

    assign w_sq_try = r_root + r_bit;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_TR_MUL: begin
                unique case (r_cnt)
                    5'd0:    begin w_ma = MUL_W'(r_s1); w_mb = MUL_W'(r_t2); end
                    5'd1:    begin w_ma = MUL_W'(r_s2); w_mb = MUL_W'(r_t1); end
                    5'd2:    begin w_ma = MUL_W'(r_t2); w_mb = MUL_W'(r_e1[0]); end
                    5'd3:    begin w_ma = MUL_W'(r_t1); w_mb = MUL_W'(r_e2[0]); end
                    5'd4:    begin w_ma = MUL_W'(r_t2); w_mb = MUL_W'(r_e1[1]); end
                    5'd5:    begin w_ma = MUL_W'(r_t1); w_mb = MUL_W'(r_e2[1]); end
                    5'd6:    begin w_ma = MUL_W'(r_t2); w_mb = MUL_W'(r_e1[2]); end
                    5'd7:    begin w_ma = MUL_W'(r_t1); w_mb = MUL_W'(r_e2[2]); end
                    default: begin w_ma = '0; w_mb = '0; end
                endcase
            end
            S_RD_DOT: begin
                if (w_j != 2'd3) begin
                    w_ma = MUL_W'(r_n[w_j]);
                    w_mb = r_t[w_j][MUL_W-1:0];
                end
            end
            S_RD_PROJ: begin
                if (w_j != 2'd3) begin
                    w_ma = MUL_W'(r_n[w_j]);
                    w_mb = $signed(r_acc[MUL_W+15:16]);
                end
            end
            S_RD_LEN: begin
                if (w_j != 2'd3) begin
                    w_ma = r_o[w_j][MUL_W-1:0];
                    w_mb = r_o[w_j][MUL_W-1:0];
                end
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider operand select
    always_comb begin
        if (r_state == S_RD_DIV) begin
            w_dvd = DVD_W'({abs40(r_o[w_j]), 16'b0});
            w_dvs = DVS_W'(r_root[31:0]);
        end else begin
            w_dvd = {r_num[w_j], 16'b0};
            w_dvs = abs49(r_det);
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        w_vaddr     = ADDR_W'(r_ia);
        w_saddr     = ADDR_W'(r_ia);
        w_vwe       = 1'b0;
        w_swe       = 1'b0;
        w_swaddr    = ADDR_W'(r_ia);
        w_swdata    = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_s_fire) begin
                    unique case (w_in_op)
                        OP_LOAD: n_state = in_range(w_in_a) ? S_LOAD : S_IDLE;
                        OP_TRI:  n_state = (in_range(w_in_a) && in_range(w_in_b) &&
                                            in_range(w_in_c)) ? S_TR_RD : S_IDLE;
                        OP_READ: n_state = in_range(w_in_a) ? S_RD_RD : S_RD_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // write vertex row and clear its sum
            S_LOAD: begin
                w_vwe   = 1'b1;
                w_swe   = 1'b1;
                n_state = S_IDLE;
            end
            // fetch the three corner rows
            S_TR_RD: begin
                w_vaddr = w_corner;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == 5'd3) begin
                    n_state = S_TR_DELTA;
                    n_cnt   = '0;
                end
            end
            S_TR_DELTA: begin
                n_state = S_TR_MUL;
                n_cnt   = '0;
            end
            // eight products, one per cycle, each captured from the product register
            S_TR_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd8) begin
                    n_state = S_TR_DET;
                    n_cnt   = '0;
                end
            end
            // drop degenerate triangles
            S_TR_DET: begin
                n_cnt   = '0;
                n_state = (w_det == '0) ? S_IDLE : S_TR_DIV;
            end
            S_TR_DIV: begin
                w_div_start = 1'b1;
                n_state     = S_TR_DIVW;
            end
            S_TR_DIVW: begin
                if (w_div_done) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_TR_DIV;
                    if (r_cnt == 5'd2) begin
                        n_cnt   = '0;
                        n_state = S_TR_SRD;
                    end
                end
            end
            // read-modify-write of each corner sum, write lands before the next read
            S_TR_SRD: begin
                w_saddr = w_corner;
                n_state = S_TR_SWR;
            end
            S_TR_SWR: begin
                w_swe    = 1'b1;
                w_swaddr = w_corner;
                w_swdata = w_sum_new;
                n_cnt    = r_cnt + 1'b1;
                n_state  = S_TR_SRD;
                if (r_cnt == 5'd2) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_RD_RD: begin
                n_state = S_RD_CAP;
            end
            S_RD_CAP: begin
                n_state = S_RD_NORM1;
            end
            S_RD_NORM1: begin
                if (r_m < LIM30) begin
                    n_state = S_RD_DOT;
                    n_cnt   = '0;
                end
            end
            S_RD_DOT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd3) begin
                    n_state = S_RD_PROJ;
                    n_cnt   = '0;
                end
            end
            S_RD_PROJ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd3) begin
                    n_state = S_RD_MAX;
                    n_cnt   = '0;
                end
            end
            S_RD_MAX: begin
                n_state = (w_omax == '0) ? S_RD_OUT : S_RD_NORM2;
            end
            S_RD_NORM2: begin
                if (r_m < LIM30 && r_m >= LIM29) begin
                    n_state = S_RD_LEN;
                    n_cnt   = '0;
                end
            end
            S_RD_LEN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd3) begin
                    n_state = S_RD_SQRT;
                    n_cnt   = '0;
                end
            end
            S_RD_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_state = S_RD_DIV;
                    n_cnt   = '0;
                end
            end
            S_RD_DIV: begin
                w_div_start = 1'b1;
                n_state     = S_RD_DIVW;
            end
            S_RD_DIVW: begin
                if (w_div_done) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RD_DIV;
                    if (r_cnt == 5'd2) begin
                        n_cnt   = '0;
                        n_state = S_RD_OUT;
                    end
                end
            end
            // hold until the output register is free
            S_RD_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    r_op     <= w_in_op;
                    r_ia     <= w_in_a;
                    r_ib     <= w_in_b;
                    r_ic     <= w_in_c;
                    r_row_in <= i_s_tdata[252:36];
                    r_zlen   <= 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        r_tan[j] <= '0;
                    end
                end
            end
            S_TR_RD: begin
                if (r_cnt != 5'd0) begin
                    r_vrow[2'(r_cnt - 1'b1)] <= w_vrdata;
                end
            end
            // saturated edge and UV deltas
            S_TR_DELTA: begin
                r_s1 <= sat32(row_tex(r_vrow[1], 0) - row_tex(r_vrow[0], 0));
                r_t1 <= sat32(row_tex(r_vrow[1], 1) - row_tex(r_vrow[0], 1));
                r_s2 <= sat32(row_tex(r_vrow[2], 0) - row_tex(r_vrow[0], 0));
                r_t2 <= sat32(row_tex(r_vrow[2], 1) - row_tex(r_vrow[0], 1));
                for (int j = 0; j < 3; j++) begin
                    r_e1[j] <= sat32(row_pos(r_vrow[1], j) - row_pos(r_vrow[0], j));
                    r_e2[j] <= sat32(row_pos(r_vrow[2], j) - row_pos(r_vrow[0], j));
                end
            end
            S_TR_MUL: begin
                if (r_cnt != 5'd0) begin
                    r_pp[3'(r_cnt - 1'b1)] <= r_prod[63:16];
                end
            end
            S_TR_DET: begin
                r_det <= w_det;
                for (int j = 0; j < 3; j++) begin
                    r_num[j] <= abs49(DVS_W'($signed(r_pp[2+2*j]) - $signed(r_pp[3+2*j])));
                    // keep the sign of num in the top bit of its s-direction slot
                    r_sdir[j][SUM_W-1] <= ($signed(r_pp[2+2*j]) < $signed(r_pp[3+2*j]));
                end
            end
            // clamp the signed quotient into the sum range
            S_TR_DIVW: begin
                if (w_div_done) begin
                    if (r_sdir[w_j][SUM_W-1] ^ r_det[DVS_W-1]) begin
                        r_sdir[w_j] <= (w_quo > Q_NEG_LIM) ? {1'b1, {(SUM_W-1){1'b0}}}
                                                          : SUM_W'(~w_quo + 1'b1);
                    end else begin
                        r_sdir[w_j] <= (w_quo > Q_POS_LIM) ? {1'b0, {(SUM_W-1){1'b1}}}
                                                          : SUM_W'(w_quo);
                    end
                end
            end
            S_RD_CAP: begin
                r_m <= w_tmax;
                for (int j = 0; j < 3; j++) begin
                    r_t[j] <= w_srdata[j*SUM_W +: SUM_W];
                    r_n[j] <= row_norm(w_vrdata, j);
                end
            end
            // bring the sum below 2^30, one bit a cycle
            S_RD_NORM1: begin
                r_acc <= '0;
                if (r_m >= LIM30) begin
                    r_m <= r_m >> 1;
                    for (int j = 0; j < 3; j++) begin
                        r_t[j] <= r_t[j] >>> 1;
                    end
                end
            end
            S_RD_DOT: begin
                if (r_cnt != 5'd0) begin
                    r_acc <= r_acc + 64'(r_prod);
                end
            end
            // subtract the normal component
            S_RD_PROJ: begin
                if (r_cnt != 5'd0) begin
                    r_o[2'(r_cnt - 1'b1)] <=
                        40'(52'(r_t[2'(r_cnt - 1'b1)]) - $signed(r_prod[2*MUL_W-1:16]));
                end
            end
            S_RD_MAX: begin
                r_m <= SUM_W'(w_omax);
                if (w_omax != '0) begin
                    r_zlen <= 1'b0;
                end
            end
            // scale the largest magnitude into [2^29, 2^30)
            S_RD_NORM2: begin
                r_acc <= '0;
                if (r_m >= LIM30) begin
                    r_m <= r_m >> 1;
                    for (int j = 0; j < 3; j++) begin
                        r_o[j] <= r_o[j] >>> 1;
                    end
                end else if (r_m < LIM29) begin
                    r_m <= r_m << 1;
                    for (int j = 0; j < 3; j++) begin
                        r_o[j] <= r_o[j] <<< 1;
                    end
                end
            end
            S_RD_LEN: begin
                if (r_cnt != 5'd0) begin
                    r_acc <= r_acc + 64'(r_prod);
                end
                r_root <= '0;
                r_bit  <= SQRT_BIT0;
            end
            // one root bit per cycle
            S_RD_SQRT: begin
                if (r_acc >= w_sq_try) begin
                    r_acc  <= r_acc - w_sq_try;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_RD_DIVW: begin
                if (w_div_done) begin
                    r_tan[w_j] <= r_o[w_j][39] ? TAN_W'(~w_quo + 1'b1) : TAN_W'(w_quo);
                end
            end
            S_RD_OUT: begin
                if (w_out_free) begin
                    r_od_idx <= r_ia;
                    r_od_z   <= r_zlen;
                    for (int j = 0; j < 3; j++) begin
                        r_od_tan[j] <= r_tan[j];
                    end
                end
            end
            default: begin
                r_prod <= w_ma * w_mb;
            end
        endcase
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_RD_OUT && w_out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {6'b0, r_od_tan[2], r_od_tan[1], r_od_tan[0], r_od_idx};
    assign o_m_tuser  = r_od_z;

`ifndef ASSERT_OFF
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_TR_DIVW || r_state == S_RD_DIVW))
        else $error("divider finished outside a wait state");

    a_det_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TR_DIV || r_state == S_TR_DIVW) |-> (r_det != '0))
        else $error("divide started on a zero determinant");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_LEN && r_cnt == 5'd0) |-> (r_m >= LIM29 && r_m < LIM30))
        else $error("projected tangent not normalized before length");

    a_zero_tan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[65:12] == '0))
        else $error("zero-length beat carries a nonzero tangent");
`endif

endmodule
